>>> rtl/bdre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bdre_pkg;

   localparam int TIME_W   = 48;
   localparam int PCT_W    = 7;
   localparam int WINDOW_W = 40;
   localparam int RATE_W   = 27;
   localparam int MIN_W    = 20;
   localparam int NUM_W    = 55;
   localparam int DIVB_W   = 33;
   localparam int STEP_W   = 6;

   localparam logic [WINDOW_W-1:0] MIN_WINDOW_RESET = 40'd600000000;
   localparam logic [WINDOW_W-1:0] US_PER_HOUR_Q8   = 40'd921600000000;
   localparam logic [25:0]         US_PER_MINUTE    = 26'd60000000;
   localparam logic [RATE_W-1:0]   RATE_MAX         = 27'd92160000;
   localparam logic [STEP_W-1:0]   STEP_LAST        = 6'd54;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_READ,
      STATE_CHECK,
      STATE_PREP,
      STATE_DIV,
      STATE_DONE
   } state_type;

endpackage
`default_nettype wire

>>> rtl/battery_discharge_rate_estimator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Battery discharge rate estimator. Each req word is one gauge sample; a sample taken
// off battery or with a negative percentage clears the sample history, any other is
// stored in a ring of HISTORY_DEPTH entries. Every sample gives one rsp word comparing
// the oldest and newest samples held: rate in Q8 percent per hour and minutes to empty,
// both saturating, zero when no estimate. For a sample with a valid estimate the rsp
// word is loaded once two 55-step bit-serial restoring dividers that run side by side
// have finished; without an estimate the dividers are skipped. The load waits while rsp
// holds a word not yet taken, and the next sample can be taken in the cycle after the
// load, so a new sample is not accepted before the last one's rsp word is loaded. A
// finished word waits in the rsp register while the next sample is accepted. csr writes
// min_window_us, accepted every cycle; write it only while the block is idle.
module battery_discharge_rate_estimator_unit #(
   parameter int HISTORY_DEPTH = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // sample_time_us[47:0], charge_percent[55:48]
   input  wire logic [0:0]  req_tuser,   // batt_flag[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // rate_q8[26:0], mins_to_empty[46:27], zero[47]
   output logic [0:0]       rsp_tuser,   // rate_valid[0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [39:0] csr_data     // min_window_us[39:0]
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   localparam int TW = bdre_pkg::TIME_W;
   localparam int PW = bdre_pkg::PCT_W;
   localparam int NW = bdre_pkg::NUM_W;
   localparam int BW = bdre_pkg::DIVB_W;
   localparam int RW = bdre_pkg::RATE_W;
   localparam int MW = bdre_pkg::MIN_W;

   bdre_pkg::state_type state_ff, state_in;

   logic [TW-1:0]          time_mem [HISTORY_DEPTH];
   logic [PW-1:0]          pct_mem  [HISTORY_DEPTH];

   logic [bdre_pkg::WINDOW_W-1:0] min_window_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       slot_ff, slot_in, oldest_in;
   logic [IDX_W-1:0]       oldest_ff;
   logic                   clear_in, accept, load_rsp;

   logic [TW-1:0]          new_t_ff, old_t_ff, dt_ff;
   logic [PW-1:0]          new_p_ff, old_p_ff, drop_ff;
   logic                   est_ok_ff;
   logic                   est_ok_in;
   logic [TW-1:0]          dt_in;

   logic [NW-1:0]          num_a_ff, num_b_ff;
   logic [TW-1:0]          div_a_ff;
   logic [BW-1:0]          div_b_ff;
   logic [TW-1:0]          rem_a_ff;
   logic [BW-1:0]          rem_b_ff;
   logic [RW-1:0]          q_a_ff;
   logic [MW-1:0]          q_b_ff;
   logic                   ovf_a_ff, ovf_b_ff;
   logic [bdre_pkg::STEP_W-1:0] step_ff;

   logic [TW:0]            sh_a, diff_a;
   logic [BW:0]            sh_b, diff_b;
   logic                   ge_a, ge_b;

   logic                   rsp_tvalid_ff;
   logic [RW-1:0]          rsp_rate_ff, rate_in;
   logic [MW-1:0]          rsp_min_ff, min_in;
   logic                   rsp_valid_bit_ff;

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // history bookkeeping for the incoming word
   always_comb begin
      clear_in = !req_tuser[0] || req_tdata[55];
      if (clear_in) begin
         count_in = '0;
         slot_in  = '0;
      end else begin
         slot_in  = (slot_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         count_in = (count_ff < CNT_W'(HISTORY_DEPTH)) ? count_ff + 1'b1 : count_ff;
      end
      oldest_in = (count_in == CNT_W'(HISTORY_DEPTH)) ? slot_in : '0;
   end

   // span and drop checks
   always_comb begin
      dt_in     = new_t_ff - old_t_ff;
      est_ok_in = (count_ff >= CNT_W'(2)) && (new_t_ff >= old_t_ff) &&
                  (old_p_ff > new_p_ff) && (dt_in >= TW'(min_window_ff));
   end

   // one restoring step per cycle in each divider
   always_comb begin
      sh_a   = {rem_a_ff, num_a_ff[NW-1]};
      ge_a   = sh_a >= {1'b0, div_a_ff};
      diff_a = sh_a - {1'b0, div_a_ff};
      sh_b   = {rem_b_ff, num_b_ff[NW-1]};
      ge_b   = sh_b >= {1'b0, div_b_ff};
      diff_b = sh_b - {1'b0, div_b_ff};
   end

   always_comb begin
      if (!est_ok_ff) begin
         rate_in = '0;
         min_in  = '0;
      end else begin
         rate_in = (ovf_a_ff || (q_a_ff > bdre_pkg::RATE_MAX)) ? bdre_pkg::RATE_MAX : q_a_ff;
         min_in  = ovf_b_ff ? '1 : q_b_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         bdre_pkg::STATE_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = bdre_pkg::STATE_READ;
            end
         end
         bdre_pkg::STATE_READ: begin
            state_in = bdre_pkg::STATE_CHECK;
         end
         bdre_pkg::STATE_CHECK: begin
            state_in = est_ok_in ? bdre_pkg::STATE_PREP : bdre_pkg::STATE_DONE;
         end
         bdre_pkg::STATE_PREP: begin
            state_in = bdre_pkg::STATE_DIV;
         end
         bdre_pkg::STATE_DIV: begin
            if (step_ff == bdre_pkg::STEP_LAST) begin
               state_in = bdre_pkg::STATE_DONE;
            end
         end
         bdre_pkg::STATE_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = bdre_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = bdre_pkg::STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bdre_pkg::STATE_IDLE;
         count_ff      <= '0;
         slot_ff       <= '0;
         min_window_ff <= bdre_pkg::MIN_WINDOW_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            count_ff <= count_in;
            slot_ff  <= slot_in;
         end
         if (csr_valid) begin
            min_window_ff <= csr_data;
         end
         if (load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (accept && !clear_in) begin
         time_mem[slot_ff] <= req_tdata[TW-1:0];
         pct_mem[slot_ff]  <= req_tdata[TW+PW-1:TW];
      end
      if (state_ff == bdre_pkg::STATE_READ) begin
         old_t_ff <= time_mem[oldest_ff];
         old_p_ff <= pct_mem[oldest_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         new_t_ff  <= req_tdata[TW-1:0];
         new_p_ff  <= req_tdata[TW+PW-1:TW];
         oldest_ff <= oldest_in;
      end
      if (state_ff == bdre_pkg::STATE_CHECK) begin
         est_ok_ff <= est_ok_in;
         dt_ff     <= dt_in;
         drop_ff   <= old_p_ff - new_p_ff;
      end
      if (state_ff == bdre_pkg::STATE_PREP) begin
         num_a_ff <= NW'(drop_ff) * NW'(bdre_pkg::US_PER_HOUR_Q8);
         num_b_ff <= NW'(new_p_ff) * NW'(dt_ff);
         div_a_ff <= dt_ff;
         div_b_ff <= BW'(drop_ff) * BW'(bdre_pkg::US_PER_MINUTE);
         rem_a_ff <= '0;
         rem_b_ff <= '0;
         q_a_ff   <= '0;
         q_b_ff   <= '0;
         ovf_a_ff <= 1'b0;
         ovf_b_ff <= 1'b0;
         step_ff  <= '0;
      end
      if (state_ff == bdre_pkg::STATE_DIV) begin
         num_a_ff <= {num_a_ff[NW-2:0], 1'b0};
         num_b_ff <= {num_b_ff[NW-2:0], 1'b0};
         rem_a_ff <= ge_a ? diff_a[TW-1:0] : sh_a[TW-1:0];
         rem_b_ff <= ge_b ? diff_b[BW-1:0] : sh_b[BW-1:0];
         q_a_ff   <= {q_a_ff[RW-2:0], ge_a};
         q_b_ff   <= {q_b_ff[MW-2:0], ge_b};
         ovf_a_ff <= ovf_a_ff || q_a_ff[RW-1];
         ovf_b_ff <= ovf_b_ff || q_b_ff[MW-1];
         step_ff  <= step_ff + 1'b1;
      end
      if (load_rsp) begin
         rsp_rate_ff      <= rate_in;
         rsp_min_ff       <= min_in;
         rsp_valid_bit_ff <= est_ok_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_min_ff, rsp_rate_ff};
   assign rsp_tuser  = rsp_valid_bit_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("sample count above history depth");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff < IDX_W'(HISTORY_DEPTH))
      else $error("write slot out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("invalid estimate with nonzero payload");

   a_rate_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RW-1:0] <= bdre_pkg::RATE_MAX)
      else $error("rate above saturation limit");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      accept && clear_in |=> count_ff == '0 && slot_ff == '0)
      else $error("history not cleared");

endmodule
`default_nettype wire
